### rtl/ksd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ksd_pkg;

  // Field widths
  localparam int unsigned ScanW  = 8;
  localparam int unsigned AsciiW = 7;
  localparam int unsigned SkW    = 4;

  typedef logic [ScanW-1:0]  scan_code_t;
  typedef logic [AsciiW-1:0] ascii_t;

  // Special-key codes
  typedef enum logic [SkW-1:0] {
    SkNone   = 4'd0,
    SkEsc    = 4'd1,
    SkUp     = 4'd2,
    SkDown   = 4'd3,
    SkLeft   = 4'd4,
    SkRight  = 4'd5,
    SkDelete = 4'd6,
    SkHome   = 4'd7,
    SkEnd    = 4'd8,
    SkPgUp   = 4'd9,
    SkPgDn   = 4'd10
  } special_e;

  // Scancode constants
  localparam scan_code_t ExtPrefix = 8'hE0;
  localparam int unsigned BreakBit = 7;
  localparam logic [6:0] KeyLShift = 7'h2A;
  localparam logic [6:0] KeyRShift = 7'h36;
  localparam logic [6:0] KeyEsc    = 7'h01;
  localparam logic [6:0] KeyUp     = 7'h48;
  localparam logic [6:0] KeyDown   = 7'h50;
  localparam logic [6:0] KeyLeft   = 7'h4B;
  localparam logic [6:0] KeyRight  = 7'h4D;
  localparam logic [6:0] KeyDelete = 7'h53;
  localparam logic [6:0] KeyHome   = 7'h47;
  localparam logic [6:0] KeyEnd    = 7'h4F;
  localparam logic [6:0] KeyPgUp   = 7'h49;
  localparam logic [6:0] KeyPgDn   = 7'h51;

  // One decoded word
  typedef struct packed {
    ascii_t   ascii_char;
    special_e special_key;
  } ksd_result_t;

  // Plain and shifted character for one make code, US layout
  typedef struct packed {
    ascii_t plain;
    ascii_t shifted;
  } ksd_chars_t;

  function automatic ksd_chars_t char_lookup(input logic [6:0] code);
    ksd_chars_t c;
    c = '{plain: 7'h00, shifted: 7'h00};
    case (code)
      7'd1:  c = '{7'h1B, 7'h1B};
      7'd2:  c = '{7'h31, 7'h21};
      7'd3:  c = '{7'h32, 7'h40};
      7'd4:  c = '{7'h33, 7'h23};
      7'd5:  c = '{7'h34, 7'h24};
      7'd6:  c = '{7'h35, 7'h25};
      7'd7:  c = '{7'h36, 7'h5E};
      7'd8:  c = '{7'h37, 7'h26};
      7'd9:  c = '{7'h38, 7'h2A};
      7'd10: c = '{7'h39, 7'h28};
      7'd11: c = '{7'h30, 7'h29};
      7'd12: c = '{7'h2D, 7'h5F};
      7'd13: c = '{7'h3D, 7'h2B};
      7'd14: c = '{7'h08, 7'h08};
      7'd15: c = '{7'h09, 7'h09};
      7'd16: c = '{7'h71, 7'h51};
      7'd17: c = '{7'h77, 7'h57};
      7'd18: c = '{7'h65, 7'h45};
      7'd19: c = '{7'h72, 7'h52};
      7'd20: c = '{7'h74, 7'h54};
      7'd21: c = '{7'h79, 7'h59};
      7'd22: c = '{7'h75, 7'h55};
      7'd23: c = '{7'h69, 7'h49};
      7'd24: c = '{7'h6F, 7'h4F};
      7'd25: c = '{7'h70, 7'h50};
      7'd26: c = '{7'h5B, 7'h7B};
      7'd27: c = '{7'h5D, 7'h7D};
      7'd28: c = '{7'h0A, 7'h0A};
      7'd30: c = '{7'h61, 7'h41};
      7'd31: c = '{7'h73, 7'h53};
      7'd32: c = '{7'h64, 7'h44};
      7'd33: c = '{7'h66, 7'h46};
      7'd34: c = '{7'h67, 7'h47};
      7'd35: c = '{7'h68, 7'h48};
      7'd36: c = '{7'h6A, 7'h4A};
      7'd37: c = '{7'h6B, 7'h4B};
      7'd38: c = '{7'h6C, 7'h4C};
      7'd39: c = '{7'h3B, 7'h3A};
      7'd40: c = '{7'h27, 7'h22};
      7'd41: c = '{7'h60, 7'h7E};
      7'd43: c = '{7'h5C, 7'h7C};
      7'd44: c = '{7'h7A, 7'h5A};
      7'd45: c = '{7'h78, 7'h58};
      7'd46: c = '{7'h63, 7'h43};
      7'd47: c = '{7'h76, 7'h56};
      7'd48: c = '{7'h62, 7'h42};
      7'd49: c = '{7'h6E, 7'h4E};
      7'd50: c = '{7'h6D, 7'h4D};
      7'd51: c = '{7'h2C, 7'h3C};
      7'd52: c = '{7'h2E, 7'h3E};
      7'd53: c = '{7'h2F, 7'h3F};
      7'd55: c = '{7'h2A, 7'h2A};
      7'd57: c = '{7'h20, 7'h20};
      default: c = '{plain: 7'h00, shifted: 7'h00};
    endcase
    return c;
  endfunction

  // Navigation key after an extended prefix
  function automatic special_e nav_lookup(input logic [6:0] code);
    special_e k;
    case (code)
      KeyUp:     k = SkUp;
      KeyDown:   k = SkDown;
      KeyLeft:   k = SkLeft;
      KeyRight:  k = SkRight;
      KeyDelete: k = SkDelete;
      KeyHome:   k = SkHome;
      KeyEnd:    k = SkEnd;
      KeyPgUp:   k = SkPgUp;
      KeyPgDn:   k = SkPgDn;
      default:   k = SkNone;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

### rtl/ksd_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Scancode channel
interface ksd_scan_if import ksd_pkg::*; ();
  logic       valid;
  logic       ready;
  scan_code_t scan_code;

  modport source (output valid, output scan_code, input ready);
  modport sink   (input valid, input scan_code, output ready);
endinterface

// Decoded character channel
interface ksd_char_if import ksd_pkg::*; ();
  logic     valid;
  logic     ready;
  ascii_t   ascii_char;
  special_e special_key;

  modport source (output valid, output ascii_char, output special_key, input ready);
  modport sink   (input valid, input ascii_char, input special_key, output ready);
endinterface

`default_nettype wire

### rtl/ksd_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module ksd_in_stage import ksd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  scan_code_t in_code_i,
  output logic       in_ready_o,
  input  logic       down_ready_i,
  output scan_code_t code_o,
  output logic       fire_o
);

  logic       valid_q, valid_d;
  scan_code_t code_q;
  logic       take;

  // word leaves when the next stage has room; a new one enters alongside
  assign fire_o     = valid_q && down_ready_i;
  assign in_ready_o = !valid_q || down_ready_i;
  assign take       = in_valid_i && in_ready_o;
  assign valid_d    = take ? 1'b1 : (fire_o ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (take) begin
      code_q <= in_code_i;
    end
  end

  assign code_o = code_q;

endmodule

`default_nettype wire

### rtl/ksd_decode.sv
`timescale 1ns / 1ps
`default_nettype none

module ksd_decode import ksd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fire_i,
  input  scan_code_t  code_i,
  output ksd_result_t result_o
);

  logic       shift_q, shift_d;
  logic       ext_q, ext_d;
  logic [6:0] key;
  logic       is_break;
  logic       is_shift;
  ksd_chars_t chars;

  assign key      = code_i[6:0];
  assign is_break = code_i[BreakBit];
  assign is_shift = (key == KeyLShift) || (key == KeyRShift);
  assign chars    = char_lookup(key);

  // flag updates and translation, in priority order
  always_comb begin
    shift_d  = shift_q;
    ext_d    = ext_q;
    result_o = '{ascii_char: '0, special_key: SkNone};
    if (code_i == ExtPrefix) begin
      ext_d = 1'b1;
    end else if (is_break) begin
      ext_d = 1'b0;
      if (is_shift) begin
        shift_d = 1'b0;
      end
    end else if (is_shift) begin
      shift_d = 1'b1;
    end else if (ext_q) begin
      ext_d                = 1'b0;
      result_o.special_key = nav_lookup(key);
    end else begin
      result_o.ascii_char = shift_q ? chars.shifted : chars.plain;
      if (key == KeyEsc) begin
        result_o.special_key = SkEsc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= 1'b0;
      ext_q   <= 1'b0;
    end else if (fire_i) begin
      shift_q <= shift_d;
      ext_q   <= ext_d;
    end
  end

endmodule

`default_nettype wire

### rtl/ksd_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module ksd_out_stage import ksd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fire_i,
  input  ksd_result_t result_i,
  output logic        room_o,
  output logic        out_valid_o,
  output ksd_result_t out_word_o,
  input  logic        out_ready_i
);

  logic        valid_q, valid_d;
  ksd_result_t word_q;

  // room when empty or when the held word is taken this cycle
  assign room_o  = !valid_q || out_ready_i;
  assign valid_d = fire_i ? 1'b1 : (out_ready_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      word_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

endmodule

`default_nettype wire

### rtl/keyboard_scancode_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Fields
// scan_i   in   scan_code[7:0]
// char_o   out  ascii_char[6:0], special_key[3:0]
//
// One word per cycle sustained while char_o is ready; char_o goes valid once the
// accepted word has passed the input register and then the result register.
// Shift and prefix flags update as a word moves into the result register.
// rst_ni clears both flags and both valid bits, asynchronously.
// A stall on char_o holds the result register; scan_i still takes one more
// word into the input register while the result waits.

module keyboard_scancode_decoder import ksd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  ksd_scan_if.sink   scan_i,
  ksd_char_if.source char_o
);

  scan_code_t  s1_code;
  logic        fire;
  logic        room;
  ksd_result_t result;
  ksd_result_t out_word;

  ksd_in_stage u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (scan_i.valid),
    .in_code_i   (scan_i.scan_code),
    .in_ready_o  (scan_i.ready),
    .down_ready_i(room),
    .code_o      (s1_code),
    .fire_o      (fire)
  );

  ksd_decode u_dec (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .code_i  (s1_code),
    .result_o(result)
  );

  ksd_out_stage u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .result_i   (result),
    .room_o     (room),
    .out_valid_o(char_o.valid),
    .out_word_o (out_word),
    .out_ready_i(char_o.ready)
  );

  assign char_o.ascii_char  = out_word.ascii_char;
  assign char_o.special_key = out_word.special_key;

endmodule

`default_nettype wire

### test/keyboard_scancode_decoder_tb.sv
`timescale 1ns / 1ps

module keyboard_scancode_decoder_tb;
  import ksd_pkg::*;

  localparam int unsigned KeyTabLen = 58;
  localparam int unsigned ItemTarget = 1350;
  localparam int unsigned MaxReports = 10;

  // Tracks shift and prefix flags, holds decoded words still due from the DUT
  class ScancodeTracker;
    bit [7:0] plain_chars[KeyTabLen];
    bit [7:0] shifted_chars[KeyTabLen];
    bit shift_down;
    bit prefix_seen;
    ksd_result_t expected_chars[$];
    int unsigned errors;

    function new();
      plain_chars = '{8'h00, 8'h1B, "1", "2", "3", "4", "5", "6", "7", "8",
                      "9", "0", "-", "=", 8'h08, 8'h09, "q", "w", "e", "r",
                      "t", "y", "u", "i", "o", "p", "[", "]", 8'h0A, 8'h00,
                      "a", "s", "d", "f", "g", "h", "j", "k", "l", ";",
                      8'h27, 8'h60, 8'h00, 8'h5C, "z", "x", "c", "v", "b", "n",
                      "m", ",", ".", "/", 8'h00, "*", 8'h00, " "};
      shifted_chars = '{8'h00, 8'h1B, "!", "@", "#", "$", "%", "^", "&", "*",
                        "(", ")", "_", "+", 8'h08, 8'h09, "Q", "W", "E", "R",
                        "T", "Y", "U", "I", "O", "P", "{", "}", 8'h0A, 8'h00,
                        "A", "S", "D", "F", "G", "H", "J", "K", "L", ":",
                        8'h22, 8'h7E, 8'h00, 8'h7C, "Z", "X", "C", "V", "B", "N",
                        "M", "<", ">", "?", 8'h00, "*", 8'h00, " "};
      shift_down = 1'b0;
      prefix_seen = 1'b0;
      errors = 0;
    endfunction

    function special_e nav_key(logic [6:0] code);
      case (code)
        KeyUp:     return SkUp;
        KeyDown:   return SkDown;
        KeyLeft:   return SkLeft;
        KeyRight:  return SkRight;
        KeyDelete: return SkDelete;
        KeyHome:   return SkHome;
        KeyEnd:    return SkEnd;
        KeyPgUp:   return SkPgUp;
        KeyPgDn:   return SkPgDn;
        default:   return SkNone;
      endcase
    endfunction

    // Decode one accepted scancode and queue the word it should produce
    function void note_scan(scan_code_t code);
      ksd_result_t r;
      bit [7:0] ch;
      r.ascii_char = '0;
      r.special_key = SkNone;
      if (code == ExtPrefix) begin
        prefix_seen = 1'b1;
      end else if (code[BreakBit]) begin
        if (code[6:0] == KeyLShift || code[6:0] == KeyRShift) shift_down = 1'b0;
        prefix_seen = 1'b0;
      end else if (code[6:0] == KeyLShift || code[6:0] == KeyRShift) begin
        // shift make keeps a pending prefix
        shift_down = 1'b1;
      end else if (prefix_seen) begin
        prefix_seen = 1'b0;
        r.special_key = nav_key(code[6:0]);
      end else begin
        if (code < KeyTabLen) begin
          ch = shift_down ? shifted_chars[code] : plain_chars[code];
          r.ascii_char = ch[6:0];
        end
        if (code[6:0] == KeyEsc) r.special_key = SkEsc;
      end
      expected_chars.push_back(r);
    endfunction

    // Compare one accepted output word with the oldest expectation
    function void check_char(ascii_t got_char, special_e got_key);
      ksd_result_t e;
      if (expected_chars.size() == 0) begin
        errors++;
        if (errors <= MaxReports)
          $display("%0t: unexpected word char=%h key=%0d", $realtime, got_char, got_key);
        return;
      end
      e = expected_chars.pop_front();
      if (got_char !== e.ascii_char || got_key !== e.special_key) begin
        errors++;
        if (errors <= MaxReports)
          $display("%0t: mismatch char exp=%h got=%h, key exp=%0d got=%0d",
                   $realtime, e.ascii_char, got_char, e.special_key, got_key);
      end
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  bit calm = 1'b0;
  int unsigned sent = 0;

  ksd_scan_if scan_if ();
  ksd_char_if char_if ();

  ScancodeTracker tracker = new();

  keyboard_scancode_decoder DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .scan_i (scan_if),
    .char_o (char_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Mostly short gaps, now and then a long one; none while calm
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Offer one scancode word and hold it until taken
  task automatic send_scan(input scan_code_t code);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      scan_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    scan_if.valid <= 1'b1;
    scan_if.scan_code <= code;
    @(posedge clk_i);
    while (!scan_if.ready) @(posedge clk_i);
    sent++;
  endtask

  // Stop sending until every outstanding word has come back
  task automatic drain();
    scan_if.valid <= 1'b0;
    do @(posedge clk_i); while (tracker.pending() != 0);
  endtask

  function automatic logic [6:0] pick_key();
    return 7'($urandom_range(0, 63));
  endfunction

  // Typing, shifted typing and navigation sequences, with raw noise mixed in
  task automatic run_random(input int unsigned target);
    int kind;
    logic [6:0] key;
    logic [6:0] typed;
    logic [6:0] nav_keys[9];
    bit mid_drained;
    nav_keys = '{KeyUp, KeyDown, KeyLeft, KeyRight, KeyDelete,
                 KeyHome, KeyEnd, KeyPgUp, KeyPgDn};
    mid_drained = 1'b0;
    while (sent < target) begin
      calm = ((sent / 200) % 5) == 3;
      if (!mid_drained && sent >= target / 2) begin
        drain();
        mid_drained = 1'b1;
      end
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        key = pick_key();
        send_scan({1'b0, key});
        if ($urandom_range(0, 3) != 0) send_scan({1'b1, key});
      end else if (kind < 55) begin
        key = $urandom_range(0, 1) ? KeyLShift : KeyRShift;
        send_scan({1'b0, key});
        repeat ($urandom_range(1, 4)) begin
          typed = pick_key();
          send_scan({1'b0, typed});
          send_scan({1'b1, typed});
        end
        if ($urandom_range(0, 4) != 0) send_scan({1'b1, key});
      end else if (kind < 80) begin
        send_scan(ExtPrefix);
        if ($urandom_range(0, 4) == 0) key = 7'($urandom_range(0, 127));
        else key = nav_keys[$urandom_range(0, 8)];
        send_scan({1'b0, key});
        if ($urandom_range(0, 1) != 0) begin
          send_scan(ExtPrefix);
          send_scan({1'b1, key});
        end
      end else begin
        send_scan(8'($urandom));
      end
    end
    calm = 1'b0;
  endtask

  // Output side: ready with random stalls
  initial begin
    int gap;
    char_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        char_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      char_if.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  // Watch both channels at each edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (scan_if.valid && scan_if.ready) tracker.note_scan(scan_if.scan_code);
      if (char_if.valid && char_if.ready)
        tracker.check_char(char_if.ascii_char, char_if.special_key);
    end
  end

  initial begin
    scan_code_t directed[$];
    rst_ni <= 1'b0;
    scan_if.valid <= 1'b0;
    scan_if.scan_code <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Table edges, holes, escape, shift, prefix repeats, breaks clearing prefix
    directed = '{8'h00, 8'h01, 8'h10, 8'h39, 8'h3A, 8'h7F, 8'h1D, 8'h2A, 8'h10,
                 8'h02, ExtPrefix, 8'h48, 8'hAA, 8'h36, ExtPrefix, ExtPrefix, 8'h2A,
                 8'h50, 8'hB6, ExtPrefix, 8'h9D, 8'h48, ExtPrefix, 8'h1E, 8'hFF};
    foreach (directed[i]) send_scan(directed[i]);
    drain();

    run_random(ItemTarget);

    scan_if.valid <= 1'b0;
    do @(posedge clk_i); while (tracker.pending() != 0);
    repeat (10) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #(10_000_000);
    $display("Regression FAIL");
    $finish;
  end

endmodule
